// ----- hw/rtl/zohr_pkg.sv -----
// Package for the zero-order-hold resampler.
// Holds the request types, the state and mode codes and the fixed constants.
// No dependencies.
package zohr_pkg;

    localparam logic [14:0] RATE_3K      = 15'd3000;
    localparam logic [14:0] RATE_4K      = 15'd4000;
    localparam logic [15:0] DOUBLE_STATE = 16'd2;
    localparam logic [4:0]  MAX_COPIES   = 5'd16;
    localparam logic [14:0] RATE_RESET   = 15'd8000;

    localparam logic [1:0] REG_IN_RATE  = 2'd0;
    localparam logic [1:0] REG_OUT_RATE = 2'd1;
    localparam logic [1:0] REG_BUDGET   = 2'd2;

    typedef struct packed {
        logic [7:0] sample;
        logic       packet_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_sample;
        logic       last_copy;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_CHECK
    } t_state;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_34,
        MODE_ACC
    } t_mode;

    typedef enum logic [1:0] {
        ALU_ADD_OUT,
        ALU_SUB_IN,
        ALU_INC
    } t_alu_op;

    typedef struct packed {
        logic [15:0] value;
        logic        flag;
    } t_alu_res;

endpackage

// ----- hw/rtl/zero_order_hold_resampler.sv -----
// Zero-order-hold resampler: repeats or drops 8-bit samples to convert rates.
// Each accepted request passes through ST_ADD (accumulator mode only) and then
// ST_CHECK, which registers its copies to the output and can be held by an output
// stall. No new request is taken until the last copy is registered to the output.
// A request that falls in a stopped packet is dropped and yields nothing.
// Reset is synchronous and active low; registers return to 8000 Hz rates and
// the budget to twice PACKET_BYTES, saturated at 1023.
module zero_order_hold_resampler #(
    parameter int PACKET_BYTES = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  zohr_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output zohr_pkg::t_out_item  o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int BUDGET_FULL = 2 * PACKET_BYTES;
    localparam logic [9:0] BUDGET_RESET = (BUDGET_FULL > 1023) ? 10'd1023
                                                               : 10'(BUDGET_FULL);

    zohr_pkg::t_state   r_state, n_state;
    zohr_pkg::t_mode    r_mode, n_mode;
    logic [14:0]        r_in_rate;
    logic [14:0]        r_tgt_rate;
    logic [9:0]         r_budget;
    logic [15:0]        r_acc, n_acc;
    logic [9:0]         r_cnt, n_cnt;
    logic               r_stopped, n_stopped;
    logic [4:0]         r_num, n_num;
    logic               r_pend, n_pend;
    logic               r_dbl, n_dbl;
    logic [7:0]         r_sample, n_sample;
    logic               r_out_valid, n_out_valid;
    zohr_pkg::t_out_item r_out, n_out;

    zohr_pkg::t_alu_op  w_op;
    zohr_pkg::t_alu_res w_alu;
    logic               w_cfg_wr;
    logic [1:0]         w_idx;
    logic               w_slot;
    logic               w_want;
    logic               w_go;

    assign pready   = 1'b1;
    assign w_idx    = paddr[3:2];
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (w_idx)
            zohr_pkg::REG_IN_RATE:  prdata = {17'd0, r_in_rate};
            zohr_pkg::REG_OUT_RATE: prdata = {17'd0, r_tgt_rate};
            zohr_pkg::REG_BUDGET:   prdata = {22'd0, r_budget};
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_rate  <= zohr_pkg::RATE_RESET;
            r_tgt_rate <= zohr_pkg::RATE_RESET;
            r_budget   <= BUDGET_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                zohr_pkg::REG_IN_RATE:  r_in_rate  <= pwdata[14:0];
                zohr_pkg::REG_OUT_RATE: r_tgt_rate <= pwdata[14:0];
                zohr_pkg::REG_BUDGET:   r_budget   <= pwdata[9:0];
                default: begin
                end
            endcase
        end
    end

    zohr_alu u_alu (
        .i_op       (w_op),
        .i_acc      (r_acc),
        .i_in_rate  (r_in_rate),
        .i_tgt_rate (r_tgt_rate),
        .o_res      (w_alu)
    );

    assign o_in_stall  = (r_state != zohr_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_slot      = !r_out_valid || !i_out_stall;
    assign w_go        = !r_pend || w_slot;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_stopped   = r_stopped;
        n_num       = r_num;
        n_pend      = r_pend;
        n_dbl       = r_dbl;
        n_sample    = r_sample;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_op        = zohr_pkg::ALU_ADD_OUT;
        w_want      = 1'b0;

        unique case (r_state)
            zohr_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_sample = i_in_data.sample;
                    n_num    = 5'd0;
                    n_pend   = 1'b0;
                    n_dbl    = 1'b0;
                    if (i_in_data.packet_start) begin
                        n_cnt     = 10'd0;
                        n_stopped = 1'b0;
                    end
                    if (r_in_rate == r_tgt_rate) begin
                        n_mode = zohr_pkg::MODE_PASS;
                    end else if (r_in_rate == zohr_pkg::RATE_3K &&
                                 r_tgt_rate == zohr_pkg::RATE_4K) begin
                        n_mode = zohr_pkg::MODE_34;
                    end else begin
                        n_mode = zohr_pkg::MODE_ACC;
                    end
                    if (!(r_stopped && !i_in_data.packet_start)) begin
                        n_state = (n_mode == zohr_pkg::MODE_ACC) ? zohr_pkg::ST_ADD
                                                                 : zohr_pkg::ST_CHECK;
                    end
                end
            end
            zohr_pkg::ST_ADD: begin
                w_op    = zohr_pkg::ALU_ADD_OUT;
                n_acc   = w_alu.value;
                n_state = zohr_pkg::ST_CHECK;
            end
            zohr_pkg::ST_CHECK: begin
                unique case (r_mode)
                    zohr_pkg::MODE_PASS: begin
                        w_want = (r_num == 5'd0);
                    end
                    zohr_pkg::MODE_34: begin
                        w_op   = zohr_pkg::ALU_INC;
                        w_want = (r_num == 5'd0) || (r_num == 5'd1 && r_dbl);
                    end
                    zohr_pkg::MODE_ACC: begin
                        w_op   = zohr_pkg::ALU_SUB_IN;
                        w_want = w_alu.flag && (r_num < zohr_pkg::MAX_COPIES);
                    end
                    default: begin
                        w_want = 1'b0;
                    end
                endcase

                if (w_go) begin
                    if (r_pend) begin
                        n_out_valid          = 1'b1;
                        n_out.out_sample     = r_sample;
                        n_out.last_copy      = 1'b1;
                    end
                    if (w_want && r_cnt < r_budget) begin
                        if (r_pend) begin
                            n_out.last_copy = 1'b0;
                        end
                        n_pend = 1'b1;
                        n_cnt  = r_cnt + 10'd1;
                        n_num  = r_num + 5'd1;
                        unique case (r_mode)
                            zohr_pkg::MODE_34: begin
                                if (r_num == 5'd0) begin
                                    n_dbl = (r_acc == zohr_pkg::DOUBLE_STATE);
                                    if (r_acc != zohr_pkg::DOUBLE_STATE) begin
                                        n_acc = w_alu.value;
                                    end
                                end else begin
                                    n_acc = 16'd0;
                                end
                            end
                            zohr_pkg::MODE_ACC: begin
                                n_acc = w_alu.value;
                            end
                            default: begin
                            end
                        endcase
                    end else begin
                        if (w_want) begin
                            n_stopped = 1'b1;
                        end
                        n_pend  = 1'b0;
                        n_state = zohr_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = zohr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= zohr_pkg::ST_IDLE;
            r_mode      <= zohr_pkg::MODE_PASS;
            r_acc       <= 16'd0;
            r_cnt       <= 10'd0;
            r_stopped   <= 1'b0;
            r_num       <= 5'd0;
            r_pend      <= 1'b0;
            r_dbl       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_stopped   <= n_stopped;
            r_num       <= n_num;
            r_pend      <= n_pend;
            r_dbl       <= n_dbl;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_out    <= n_out;
    end

endmodule

// ----- hw/rtl/zohr_alu.sv -----
// Shared phase arithmetic unit of the zero-order-hold resampler.
// One 17-bit adder/subtractor for rate add, rate subtract and counter step.
// Depends on zohr_pkg.
module zohr_alu (
    input  zohr_pkg::t_alu_op  i_op,
    input  logic [15:0]        i_acc,
    input  logic [14:0]        i_in_rate,
    input  logic [14:0]        i_tgt_rate,
    output zohr_pkg::t_alu_res o_res
);

    logic [16:0] w_b;
    logic        w_sub;
    logic [16:0] w_sum;

    always_comb begin
        w_sub = 1'b0;
        unique case (i_op)
            zohr_pkg::ALU_ADD_OUT: begin
                w_b = {2'b00, i_tgt_rate};
            end
            zohr_pkg::ALU_SUB_IN: begin
                w_b   = {2'b00, i_in_rate};
                w_sub = 1'b1;
            end
            zohr_pkg::ALU_INC: begin
                w_b = 17'd1;
            end
            default: begin
                w_b = 17'd0;
            end
        endcase
        w_sum = w_sub ? ({1'b0, i_acc} - w_b) : ({1'b0, i_acc} + w_b);

        // Flag is the carry for additions and "no borrow" (acc >= rate) for subtraction.
        o_res.flag = w_sub ? ~w_sum[16] : w_sum[16];
        if (i_op == zohr_pkg::ALU_ADD_OUT && w_sum[16]) begin
            o_res.value = 16'hFFFF;
        end else begin
            o_res.value = w_sum[15:0];
        end
    end

endmodule

// ----- hw/rtl/zohr_checker.sv -----
// Port checker for the zero-order-hold resampler, bound to its top level.
// Watches the request channels only. Depends on zohr_pkg.
module zohr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input zohr_pkg::t_out_item o_out_data
);

    // A stalled result request holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result request changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

    // More copies follow a copy that is not the last, so the input stays busy.
    a_busy_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last_copy |-> o_in_stall)
        else $error("input ready while copies remain");

    // The next copy is valid in the cycle after a non-final copy is taken.
    a_next_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_data.last_copy |=> o_out_valid)
        else $error("gap after a non-final copy");

endmodule

bind zero_order_hold_resampler zohr_checker u_zohr_checker (.*);
